// ===== hw/rtl/dide_pkg.sv =====
// Shared types and constants for the debounce and event-log block.
package dide_pkg;

   localparam int PORT_W = 16;
   localparam int TIME_W = 32;
   localparam int CHAN_W = 4;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_MASK    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_MASK    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_MASK     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_TICKS    = 3'd4;

   typedef struct packed {
      logic [PORT_W-1:0] raw_sample;
      logic [TIME_W-1:0] tick_time;
   } req_type;

   typedef struct packed {
      logic              event_valid;
      logic [CHAN_W-1:0] channel;
      logic              new_value;
      logic [TIME_W-1:0] change_time;
      logic [PORT_W-1:0] confirmed_bits;
      logic [PORT_W-1:0] filtered_bits;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [PORT_W-1:0] invert_mask;
      logic [PORT_W-1:0] enable_mask;
      logic [PORT_W-1:0] debounce_ticks;
      logic [PORT_W-1:0] pulse_mask;
      logic [PORT_W-1:0] pulse_debounce_ticks;
   } cfg_type;

   // One scan tick after classification: which channels report, and their stamps.
   typedef struct packed {
      logic [PORT_W-1:0]             ev_mask;
      logic [PORT_W-1:0]             filtered;
      logic [PORT_W-1:0]             confirmed;
      logic [PORT_W-1:0][TIME_W-1:0] times;
   } tick_rec_type;

endpackage

// ===== hw/rtl/digital_input_debounce_soe.sv =====
// Top level of the debounce filter with change-event log.
//
//  port group   dir  handshake          payload
//  req_*        in   req_valid/stall    raw_sample, tick_time
//  rsp_*        out  rsp_valid/stall    event, channel, value, time, words, last
//  csr_*        in   csr_we             csr_index, csr_wdata
//
// A tick gives max(1, events) results; the back end's walk over the event mask,
// one result per cycle while the output is not stalled, sets the rate. The
// front end takes a tick while the two-entry queue has room. Reset is synchronous;
// control state is zero and invert_mask is all ones after it. A stalled output
// holds and backs up through the queue to req_stall.
module digital_input_debounce_soe #(
   parameter int CHANNELS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  dide_pkg::req_type                   req_data,
   output logic                                req_stall,
   output logic                                rsp_valid,
   output dide_pkg::rsp_type                   rsp_data,
   input  logic                                rsp_stall,
   input  logic                                csr_we,
   input  logic [dide_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dide_pkg::PORT_W-1:0]         csr_wdata
);

   dide_pkg::cfg_type      cfg_ff, cfg_in;
   dide_pkg::tick_rec_type push_rec, head_rec;
   logic                   push, pop, q_full, q_not_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dide_pkg::CSR_INVERT_MASK:    cfg_in.invert_mask          = csr_wdata;
            dide_pkg::CSR_ENABLE_MASK:    cfg_in.enable_mask          = csr_wdata;
            dide_pkg::CSR_DEBOUNCE_TICKS: cfg_in.debounce_ticks       = csr_wdata;
            dide_pkg::CSR_PULSE_MASK:     cfg_in.pulse_mask           = csr_wdata;
            dide_pkg::CSR_PULSE_TICKS:    cfg_in.pulse_debounce_ticks = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.invert_mask          <= '1;
         cfg_ff.enable_mask          <= '0;
         cfg_ff.debounce_ticks       <= '0;
         cfg_ff.pulse_mask           <= '0;
         cfg_ff.pulse_debounce_ticks <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dide_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .push      (push),
      .push_rec  (push_rec)
   );

   dide_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .pop       (pop),
      .head_rec  (head_rec),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   dide_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_rec    (head_rec),
      .q_not_empty (q_not_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall)
   );

endmodule

// ===== hw/rtl/dide_front.sv =====
// Front end: filters each scan tick, runs the per-channel debounce counters.
module dide_front #(
   parameter int CHANNELS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  dide_pkg::req_type      req_data,
   output logic                   req_stall,
   input  dide_pkg::cfg_type      cfg,
   input  logic                   q_full,
   output logic                   push,
   output dide_pkg::tick_rec_type push_rec
);

   localparam logic [dide_pkg::PORT_W-1:0] CHAN_MASK =
      dide_pkg::PORT_W'((32'd1 << CHANNELS) - 32'd1);

   logic [dide_pkg::PORT_W-1:0] prev_ff, prev_in;
   logic [dide_pkg::PORT_W-1:0] flags_ff, flags_in;
   logic [dide_pkg::PORT_W-1:0] conf_ff, conf_in;
   logic [dide_pkg::PORT_W-1:0] cnt_ff [CHANNELS];
   logic [dide_pkg::PORT_W-1:0] cnt_in [CHANNELS];
   logic [dide_pkg::TIME_W-1:0] time_ff [CHANNELS];
   logic [dide_pkg::TIME_W-1:0] time_in [CHANNELS];
   logic [dide_pkg::PORT_W-1:0] filt, changed, ev;
   logic                        accept;

   assign accept    = req_valid & ~q_full;
   assign req_stall = q_full;
   assign push      = accept;

   always_comb begin
      logic [dide_pkg::PORT_W-1:0] dt;
      filt     = (req_data.raw_sample ^ cfg.invert_mask) & cfg.enable_mask & CHAN_MASK;
      changed  = filt ^ prev_ff;
      prev_in  = filt;
      flags_in = flags_ff;
      conf_in  = conf_ff;
      ev       = '0;
      dt       = '0;
      push_rec.times = '0;
      for (int j = 0; j < CHANNELS; j++) begin
         cnt_in[j]  = cnt_ff[j];
         time_in[j] = time_ff[j];
         dt = cfg.pulse_mask[j] ? cfg.pulse_debounce_ticks : cfg.debounce_ticks;
         // load of time+1 and the same-tick decrement fold into a load of time
         if (changed[j]) begin
            flags_in[j] = 1'b1;
            cnt_in[j]   = dt;
            time_in[j]  = req_data.tick_time;
         end else if (flags_ff[j]) begin
            if (cnt_ff[j] == '0) begin
               flags_in[j] = 1'b0;
               if (filt[j] != conf_ff[j]) begin
                  conf_in[j]        = filt[j];
                  ev[j]             = ~cfg.pulse_mask[j];
                  push_rec.times[j] = time_ff[j];
               end
            end else begin
               cnt_in[j] = cnt_ff[j] - 16'd1;
            end
         end
      end
      push_rec.ev_mask   = ev;
      push_rec.filtered  = filt;
      push_rec.confirmed = conf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         flags_ff <= '0;
         conf_ff  <= '0;
      end else if (accept) begin
         prev_ff  <= prev_in;
         flags_ff <= flags_in;
         conf_ff  <= conf_in;
      end
   end

   // counters and stamps are only read after a load, so they need no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int j = 0; j < CHANNELS; j++) begin
            cnt_ff[j]  <= cnt_in[j];
            time_ff[j] <= time_in[j];
         end
      end
   end

endmodule

// ===== hw/rtl/dide_queue.sv =====
// Two-entry queue of classified ticks between front and back end.
module dide_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dide_pkg::tick_rec_type push_rec,
   input  logic                   pop,
   output dide_pkg::tick_rec_type head_rec,
   output logic                   not_empty,
   output logic                   full
);

   dide_pkg::tick_rec_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign head_rec  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ===== hw/rtl/dide_back.sv =====
// Back end: sends a tick's events in channel order, one per unstalled cycle.
module dide_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dide_pkg::tick_rec_type head_rec,
   input  logic                   q_not_empty,
   output logic                   pop,
   output logic                   rsp_valid,
   output dide_pkg::rsp_type      rsp_data,
   input  logic                   rsp_stall
);

   logic [dide_pkg::PORT_W-1:0] done_ff, done_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   dide_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic [dide_pkg::PORT_W-1:0] remaining, onehot, rest;
   logic [dide_pkg::CHAN_W-1:0] idx;
   logic                        slot_free, fire, is_last;

   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign fire      = q_not_empty & slot_free;
   assign remaining = head_rec.ev_mask & ~done_ff;

   always_comb begin
      idx = '0;
      for (int j = dide_pkg::PORT_W - 1; j >= 0; j--) begin
         if (remaining[j]) begin
            idx = dide_pkg::CHAN_W'(j);
         end
      end
   end

   assign onehot  = remaining[idx] ? (16'd1 << idx) : '0;
   assign rest    = remaining & ~onehot;
   assign is_last = (rest == '0);
   assign pop     = fire & is_last;

   always_comb begin
      rsp_data_in.event_valid    = remaining[idx];
      rsp_data_in.channel        = remaining[idx] ? idx : '0;
      rsp_data_in.new_value      = remaining[idx] & head_rec.filtered[idx];
      rsp_data_in.change_time    = remaining[idx] ? head_rec.times[idx] : '0;
      rsp_data_in.confirmed_bits = head_rec.confirmed;
      rsp_data_in.filtered_bits  = head_rec.filtered;
      rsp_data_in.last           = is_last;
      rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);
      done_in      = done_ff;
      if (fire) begin
         done_in = is_last ? '0 : (done_ff | onehot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/dide_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module dide_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input dide_pkg::rsp_type rsp_data,
   input logic              rsp_stall
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.event_valid |->
         rsp_data.last && rsp_data.channel == 4'd0 && !rsp_data.new_value &&
         rsp_data.change_time == 32'd0)
      else $error("status result not in its idle form");

   a_event_confirmed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_valid |->
         rsp_data.confirmed_bits[rsp_data.channel] == rsp_data.new_value)
      else $error("event value disagrees with confirmed word");

   a_event_filtered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_valid |->
         rsp_data.filtered_bits[rsp_data.channel] == rsp_data.new_value)
      else $error("event value disagrees with filtered word");

endmodule

bind digital_input_debounce_soe dide_checker u_dide_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .rsp_stall (rsp_stall)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the input debounce filter with change-event log.
`timescale 1ns / 100ps

import dide_pkg::*;

class debounce_scoreboard;
   cfg_type           cfg;
   logic [PORT_W-1:0] prev_word;
   logic [PORT_W-1:0] filtering;
   logic [PORT_W-1:0] confirmed;
   logic [16:0]       count [PORT_W];
   logic [TIME_W-1:0] stamp [PORT_W];
   rsp_type           expected_reports [$];
   int                mismatches;

   function new();
      cfg = '0;
      cfg.invert_mask = '1;
      prev_word = '0;
      filtering = '0;
      confirmed = '0;
      mismatches = 0;
      for (int j = 0; j < PORT_W; j++) begin
         count[j] = '0;
         stamp[j] = '0;
      end
   endfunction

   function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [PORT_W-1:0] val);
      case (idx)
         CSR_INVERT_MASK:    cfg.invert_mask = val;
         CSR_ENABLE_MASK:    cfg.enable_mask = val;
         CSR_DEBOUNCE_TICKS: cfg.debounce_ticks = val;
         CSR_PULSE_MASK:     cfg.pulse_mask = val;
         CSR_PULSE_TICKS:    cfg.pulse_debounce_ticks = val;
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_reports.size();
   endfunction

   // One scan tick: update filter state and queue the reports it produces.
   function void note_tick(req_type r);
      logic [PORT_W-1:0] filt;
      logic [PORT_W-1:0] changed;
      rsp_type           rec;
      rsp_type           reports [$];
      filt = (r.raw_sample ^ cfg.invert_mask) & cfg.enable_mask;
      changed = filt ^ prev_word;
      prev_word = filt;
      filtering = filtering | changed;
      for (int j = 0; j < PORT_W; j++) begin
         if (!filtering[j])
            continue;
         if (changed[j]) begin
            count[j] = (cfg.pulse_mask[j] ? {1'b0, cfg.pulse_debounce_ticks}
                                          : {1'b0, cfg.debounce_ticks}) + 17'd1;
            stamp[j] = r.tick_time;
         end
         if (count[j] == '0) begin
            filtering[j] = 1'b0;
            if (filt[j] != confirmed[j]) begin
               confirmed[j] = filt[j];
               // pulse channels confirm silently
               if (!cfg.pulse_mask[j]) begin
                  rec = '0;
                  rec.event_valid = 1'b1;
                  rec.channel = 4'(j);
                  rec.new_value = filt[j];
                  rec.change_time = stamp[j];
                  reports.push_back(rec);
               end
            end
         end else begin
            count[j] = count[j] - 17'd1;
         end
      end
      if (reports.size() == 0) begin
         rec = '0;
         reports.push_back(rec);
      end
      foreach (reports[k]) begin
         reports[k].confirmed_bits = confirmed;
         reports[k].filtered_bits = filt;
         reports[k].last = (k == reports.size() - 1);
         expected_reports.push_back(reports[k]);
      end
   endfunction

   function string describe(rsp_type r);
      return $sformatf("ev=%0b ch=%0d val=%0b time=%h conf=%h filt=%h last=%0b",
                       r.event_valid, r.channel, r.new_value, r.change_time,
                       r.confirmed_bits, r.filtered_bits, r.last);
   endfunction

   function void check_report(rsp_type got);
      rsp_type want;
      bit      bad;
      if (expected_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected report %s", $time, describe(got));
         return;
      end
      want = expected_reports.pop_front();
      bad = (got.event_valid !== want.event_valid) || (got.channel !== want.channel) ||
            (got.new_value !== want.new_value) || (got.change_time !== want.change_time) ||
            (got.confirmed_bits !== want.confirmed_bits) ||
            (got.filtered_bits !== want.filtered_bits) || (got.last !== want.last);
      if (bad) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: report mismatch", $time);
            $display("   expected %s", describe(want));
            $display("   actual   %s", describe(got));
         end
      end
   endfunction
endclass

module tb;
   import dide_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   req_type                req_data = '0;
   logic                   req_stall;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   rsp_stall = 1'b0;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [PORT_W-1:0]      csr_wdata = '0;

   debounce_scoreboard sb;
   bit                 tx_idle = 1'b0;
   bit                 rx_idle = 1'b0;
   bit                 hold_off = 1'b0;
   logic [TIME_W-1:0]  now_stamp = '0;
   logic [PORT_W-1:0]  cur_word = '0;

   digital_input_debounce_soe dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_tick(req_data);
         if (rsp_valid && !rsp_stall)
            sb.check_report(rsp_data);
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // called just after a rising edge; returns at the edge that takes the request
   task automatic send_tick(input logic [PORT_W-1:0] raw);
      if (tx_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{raw_sample: raw, tick_time: now_stamp};
      now_stamp = now_stamp + 32'($urandom_range(1, 500));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic configure(input cfg_type c);
      logic [PORT_W-1:0] vals [5];
      vals[0] = c.invert_mask;
      vals[1] = c.enable_mask;
      vals[2] = c.debounce_ticks;
      vals[3] = c.pulse_mask;
      vals[4] = c.pulse_debounce_ticks;
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= vals[i];
         sb.set_register(CSR_INDEX_W'(i), vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // mostly held words with a few toggling bits, some full-word noise
   task automatic run_random(input int n, input int hold_at);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            cur_word = 16'($urandom());
         else if (pick < 35)
            repeat ($urandom_range(1, 3)) cur_word = cur_word ^ (16'(1) << $urandom_range(0, 15));
         if ($urandom_range(0, 19) == 0)
            now_stamp = $urandom();
         if (i == hold_at)
            hold_off = 1'b1;
         send_tick(cur_word);
      end
      wait_idle();
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: everything disabled, status reports only
      send_tick(16'h0000);
      now_stamp = '1;
      send_tick(16'hFFFF);
      wait_idle();

      // no debounce: changed channels confirm together, up to sixteen events per tick
      configure('{invert_mask: 16'h0000, enable_mask: 16'hFFFF, debounce_ticks: 16'h0000,
                  pulse_mask: 16'h0000, pulse_debounce_ticks: 16'h0000});
      now_stamp = '0;
      send_tick(16'hFFFF);
      send_tick(16'hFFFF);
      send_tick(16'h0000);
      now_stamp = '1;
      send_tick(16'h0000);
      send_tick(16'hA5A5);
      send_tick(16'h5A5A);
      send_tick(16'h5A5A);
      send_tick(16'h5A5A);
      wait_idle();

      // longest debounce on ordinary channels: 17-bit counter must not wrap
      rx_idle = 1'b1;
      configure('{invert_mask: 16'hFFFF, enable_mask: 16'h0F0F, debounce_ticks: 16'hFFFF,
                  pulse_mask: 16'h00FF, pulse_debounce_ticks: 16'h0000});
      send_tick(16'h0000);
      send_tick(16'h0000);
      send_tick(16'h0000);
      send_tick(16'hFFFF);
      send_tick(16'hFFFF);
      wait_idle();

      // settings changed with counters still loaded
      tx_idle = 1'b1;
      configure('{invert_mask: 16'h0000, enable_mask: 16'hFFFF, debounce_ticks: 16'h0001,
                  pulse_mask: 16'hFF00, pulse_debounce_ticks: 16'hFFFF});
      send_tick(16'h1234);
      send_tick(16'h1234);
      send_tick(16'h1234);
      send_tick(16'h1234);
      send_tick(16'hFFFF);
      wait_idle();

      configure('{invert_mask: 16'($urandom()), enable_mask: 16'hFFFF,
                  debounce_ticks: 16'($urandom_range(0, 3)), pulse_mask: 16'($urandom()),
                  pulse_debounce_ticks: 16'($urandom_range(0, 3))});
      run_random(60, -1);

      tx_idle = 1'b0;
      configure('{invert_mask: 16'h0000, enable_mask: 16'($urandom()), debounce_ticks: 16'h0000,
                  pulse_mask: 16'h0000, pulse_debounce_ticks: 16'hFFFF});
      run_random(60, 15);

      tx_idle = 1'b1;
      rx_idle = 1'b0;
      configure('{invert_mask: 16'hFFFF, enable_mask: 16'hFFFF,
                  debounce_ticks: 16'($urandom_range(2, 6)), pulse_mask: 16'h0F0F,
                  pulse_debounce_ticks: 16'h0001});
      run_random(60, -1);

      tx_idle = 1'b0;
      configure('{invert_mask: 16'($urandom()), enable_mask: 16'hFFFF, debounce_ticks: 16'h0001,
                  pulse_mask: 16'h0000, pulse_debounce_ticks: 16'h0000});
      run_random(50, -1);

      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/dide_pkg.sv
hw/rtl/dide_front.sv
hw/rtl/dide_queue.sv
hw/rtl/dide_back.sv
hw/rtl/digital_input_debounce_soe.sv
hw/rtl/dide_checker.sv
tb/tb.sv
